// ===== src/sspq_pkg.sv =====
package sspq_pkg;

  // Request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_POPPED    = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  priority_req;
    logic [9:0]  depth;
    logic [35:0] board_key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [9:0]  out_depth;
    logic [35:0] out_board;
    logic [6:0]  entry_count;
    logic        is_empty;
    logic [7:0]  front_priority;
    logic [9:0]  front_depth;
  } rsp_t;

  // One stored search node
  typedef struct packed {
    logic        valid;
    logic [7:0]  pri;
    logic [9:0]  depth;
    logic [35:0] board;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_ctrl_t;

endpackage

// ===== src/sspq_cell.sv =====
module sspq_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  sspq_pkg::cell_ctrl_t  ctrl,
  input  sspq_pkg::entry_t      prev,
  input  logic                  prev_goes,
  input  sspq_pkg::entry_t      succ,
  output sspq_pkg::entry_t      cur,
  output logic                  goes,
  output sspq_pkg::entry_t      nxt
);
  import sspq_pkg::*;

  entry_t slot;

  // New entry belongs at or before this slot (strict compare keeps ties stable)
  assign goes = !slot.valid || (slot.pri > ctrl.ent.pri);

  // Shift right on insert, shift left on pop
  always_comb begin
    nxt = slot;
    if (ctrl.ins) begin
      if (prev_goes) begin
        nxt = prev;
      end else if (goes) begin
        nxt = ctrl.ent;
      end
    end else if (ctrl.pop) begin
      nxt = succ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= nxt.valid;
    end
    slot.pri   <= nxt.pri;
    slot.depth <= nxt.depth;
    slot.board <= nxt.board;
  end

  assign cur = slot;

endmodule

// ===== src/stable_sorted_priority_queue.sv =====
// Stable min-priority queue of search nodes, kept sorted in a row of cells.
// Request channel (req, req_valid, req_stall): kind selects insert or pop;
// an insert carries priority, depth and a 36-bit board. A transfer happens
// when req_valid is high and req_stall is low.
// Response channel (rsp, rsp_valid, rsp_stall): exactly one response per
// request, in order, giving status, the popped entry (zero otherwise), the
// entry count afterwards and the new front entry.
// Every cell compares its key with the incoming one in parallel and shifts
// one place toward its neighbor, so one request completes each cycle when
// not stalled; the response is registered in the cycle after the transfer.
// Equal priorities leave in arrival order. A pop on an empty queue reports
// underflow, an insert into a full queue is dropped and reports overflow.
// Reset clears the valid bit of every cell and the entry count; no
// clearing pass is needed. While the receiver stalls a pending response,
// req_stall is raised and the queue holds its contents.
module stable_sorted_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  sspq_pkg::req_t  req,
  input  logic            req_valid,
  output logic            req_stall,
  output sspq_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_stall
);
  import sspq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  cell_ctrl_t      ctrl;
  entry_t          cur    [CAPACITY];
  entry_t          nxt    [CAPACITY];
  entry_t          prev_e [CAPACITY];
  entry_t          succ_e [CAPACITY];
  logic            goes   [CAPACITY];
  logic            prev_g [CAPACITY];
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [6:0]      count7;
  logic            accept;
  logic            is_ins;
  logic            full;
  logic            empty;
  rsp_t            rsp_next;

  // Output register: a new transfer is taken whenever the slot is free or drains
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign is_ins    = (req.kind == KIND_INSERT);
  assign full      = cur[CAPACITY-1].valid;
  assign empty     = !cur[0].valid;

  assign ctrl.ins = accept && is_ins && !full;
  assign ctrl.pop = accept && !is_ins && !empty;
  assign ctrl.ent = '{valid: 1'b1, pri: req.priority_req, depth: req.depth,
                      board: req.board_key};

  // Row of cells with neighbor links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_e[i] = '0;
      assign prev_g[i] = 1'b0;
    end else begin : g_mid
      assign prev_e[i] = cur[i-1];
      assign prev_g[i] = goes[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign succ_e[i] = '0;
    end else begin : g_inner
      assign succ_e[i] = cur[i+1];
    end

    sspq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev      (prev_e[i]),
      .prev_goes (prev_g[i]),
      .succ      (succ_e[i]),
      .cur       (cur[i]),
      .goes      (goes[i]),
      .nxt       (nxt[i])
    );
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  if (CW >= 7) begin : g_cnt_trunc
    assign count7 = count_next[6:0];
  end else begin : g_cnt_ext
    assign count7 = {{(7 - CW){1'b0}}, count_next};
  end

  // Response fields
  always_comb begin
    rsp_next = '0;
    if (is_ins) begin
      rsp_next.status = full ? ST_OVERFLOW : ST_INSERTED;
    end else if (empty) begin
      rsp_next.status = ST_UNDERFLOW;
    end else begin
      rsp_next.status       = ST_POPPED;
      rsp_next.out_priority = cur[0].pri;
      rsp_next.out_depth    = cur[0].depth;
      rsp_next.out_board    = cur[0].board;
    end
    rsp_next.entry_count = count7;
    rsp_next.is_empty    = !nxt[0].valid;
    if (nxt[0].valid) begin
      rsp_next.front_priority = nxt[0].pri;
      rsp_next.front_depth    = nxt[0].depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Count tracks the valid bits at both ends of the row
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !cur[0].valid)
    else $error("entry count disagrees with front cell valid");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(CAPACITY)) == cur[CAPACITY-1].valid)
    else $error("entry count disagrees with last cell valid");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> (count == $past(count) + CW'(1)))
    else $error("insert did not raise entry count");

  a_pop_front: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> (rsp_valid && rsp.status == ST_POPPED && rsp.out_priority == $past(cur[0].pri)))
    else $error("pop did not return the front entry");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import sspq_pkg::*;

  localparam int QUEUE_DEPTH     = 64;
  localparam int ITEMS_PER_PHASE = 644;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 10;

  // One search node as held by the shadow queue
  typedef struct packed {
    logic [7:0]  pri;
    logic [9:0]  depth;
    logic [35:0] board;
  } node_t;

  // Shadow copy of the sorted queue plus the expected responses in order
  class pq_scoreboard;
    node_t nodes[$];
    rsp_t  exp_rsps[$];
    int    mismatches;
    int    n_checked;
    int    n_inserts;
    int    n_pops;
    int    n_underflow;
    int    n_overflow;
    int    peak_count;

    function new();
      mismatches  = 0;
      n_checked   = 0;
      n_inserts   = 0;
      n_pops      = 0;
      n_underflow = 0;
      n_overflow  = 0;
      peak_count  = 0;
    endfunction

    // Apply one accepted request to the shadow queue and queue its response
    function void note_request(req_t r);
      rsp_t  e;
      node_t n;
      int    pos;
      e = '0;
      if (r.kind == KIND_INSERT) begin
        if (nodes.size() >= QUEUE_DEPTH) begin
          e.status = ST_OVERFLOW;
          n_overflow++;
        end else begin
          // stable: skip every stored node with equal or lower key
          pos = 0;
          while (pos < nodes.size() && nodes[pos].pri <= r.priority_req) pos++;
          n.pri   = r.priority_req;
          n.depth = r.depth;
          n.board = r.board_key;
          nodes.insert(pos, n);
          e.status = ST_INSERTED;
          n_inserts++;
        end
      end else begin
        if (nodes.size() == 0) begin
          e.status = ST_UNDERFLOW;
          n_underflow++;
        end else begin
          n = nodes.pop_front();
          e.status       = ST_POPPED;
          e.out_priority = n.pri;
          e.out_depth    = n.depth;
          e.out_board    = n.board;
          n_pops++;
        end
      end
      e.entry_count = 7'(nodes.size());
      e.is_empty    = (nodes.size() == 0);
      if (nodes.size() != 0) begin
        e.front_priority = nodes[0].pri;
        e.front_depth    = nodes[0].depth;
      end
      if (nodes.size() > peak_count) peak_count = nodes.size();
      exp_rsps.push_back(e);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: response %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, n_checked, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one response transfer with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t want;
      if (exp_rsps.size() == 0) begin
        $display("%0t: unexpected response, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = exp_rsps.pop_front();
      check_field("status",         64'(want.status),         64'(got.status));
      check_field("out_priority",   64'(want.out_priority),   64'(got.out_priority));
      check_field("out_depth",      64'(want.out_depth),      64'(got.out_depth));
      check_field("out_board",      64'(want.out_board),      64'(got.out_board));
      check_field("entry_count",    64'(want.entry_count),    64'(got.entry_count));
      check_field("is_empty",       64'(want.is_empty),       64'(got.is_empty));
      check_field("front_priority", 64'(want.front_priority), 64'(got.front_priority));
      check_field("front_depth",    64'(want.front_depth),    64'(got.front_depth));
      n_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  req_t        req;
  logic        req_valid;
  logic        req_stall;
  rsp_t        rsp;
  logic        rsp_valid;
  logic        rsp_stall;

  int          tx_idle_pct;
  int          rx_idle_pct;
  int unsigned cycle_count = 0;
  pq_scoreboard sb;

  stable_sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, sb.exp_rsps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99, 0) < rx_idle_pct);
    end
  end

  // Monitor: a response never belongs to a request from the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (req_valid && !req_stall) sb.note_request(req);
    end
  end

  function automatic req_t make_item(logic kind, logic [7:0] pri, logic [9:0] dep,
                                     logic [35:0] brd);
    req_t r;
    r.kind         = kind;
    r.priority_req = pri;
    r.depth        = dep;
    r.board_key    = brd;
    return r;
  endfunction

  function automatic req_t random_item(bit pop, int pri_hi);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return make_item(pop ? KIND_POP : KIND_INSERT, 8'($urandom_range(pri_hi, 0)),
                     10'($urandom_range(1023, 0)), w[35:0]);
  endfunction

  // Drive one request and hold it until the transfer
  task automatic send_req(input req_t r);
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Hold off until every expected response has come back
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.exp_rsps.size() != 0) @(negedge clk);
  endtask

  // Bursts of fill, drain and mixed traffic; narrow key ranges force ties
  task automatic run_traffic(input int n_items);
    int sent;
    int burst;
    int p_pop;
    int pri_hi;
    int k;
    sent = 0;
    // open with a fill past capacity so overflow is reached every phase
    for (k = 0; k < QUEUE_DEPTH + 4 && sent < n_items; k++) begin
      send_req(random_item(1'b0, 255));
      sent++;
    end
    while (sent < n_items) begin
      case ($urandom_range(4, 0))
        0:       begin p_pop = 5;  burst = $urandom_range(90, 60); end
        1:       begin p_pop = 85; burst = $urandom_range(90, 40); end
        2:       begin p_pop = 50; burst = $urandom_range(60, 10); end
        3:       begin p_pop = 30; burst = $urandom_range(60, 10); end
        default: begin p_pop = 65; burst = $urandom_range(60, 10); end
      endcase
      case ($urandom_range(2, 0))
        0:       pri_hi = 3;
        1:       pri_hi = 15;
        default: pri_hi = 255;
      endcase
      for (k = 0; k < burst && sent < n_items; k++) begin
        send_req(random_item($urandom_range(99, 0) < p_pop, pri_hi));
        sent++;
      end
    end
  endtask

  initial begin
    int i;
    int errors;
    sb          = new();
    rst         = 1'b1;
    req         = '0;
    req_valid   = 1'b0;
    tx_idle_pct = 33;
    rx_idle_pct = 55;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: underflow, field extremes, ties at front and middle
    send_req(make_item(KIND_POP, 8'hFF, 10'h3FF, 36'hF_FFFF_FFFF));
    send_req(make_item(KIND_INSERT, 8'd255, 10'd1023, 36'hF_FFFF_FFFF));
    send_req(make_item(KIND_INSERT, 8'd0, 10'd0, 36'h0));
    send_req(make_item(KIND_INSERT, 8'd128, 10'd5, 36'h1_2345_6780));
    send_req(make_item(KIND_INSERT, 8'd128, 10'd6, 36'h8_7654_3210));
    send_req(make_item(KIND_INSERT, 8'd128, 10'd7, 36'hA_5A5A_5A5A));
    send_req(make_item(KIND_INSERT, 8'd0, 10'd1, 36'h5_A5A5_A5A5));
    send_req(make_item(KIND_INSERT, 8'd255, 10'd2, 36'h0_0000_0001));
    send_req(make_item(KIND_INSERT, 8'd127, 10'd512, 36'h8_0000_0000));
    for (i = 0; i < 8; i++) send_req(make_item(KIND_POP, 8'd0, 10'd0, 36'h0));
    send_req(make_item(KIND_POP, 8'd0, 10'd0, 36'h0));
    wait_drained();

    run_traffic(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 55;
    rx_idle_pct = 33;
    run_traffic(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(ITEMS_PER_PHASE);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d pops, %0d underflows, %0d overflows, peak fill %0d",
             sb.n_inserts, sb.n_pops, sb.n_underflow, sb.n_overflow, sb.peak_count);
    $display("%0d responses checked under three sender/receiver stall mixes",
             sb.n_checked);
    errors = sb.mismatches + sb.exp_rsps.size();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.exp_rsps.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
